FILE: hdl/stream_credit_flow_control_assert.svh
// Assertion macros used by the checker file.
`ifndef STREAM_CREDIT_FLOW_CONTROL_ASSERT_SVH
`define STREAM_CREDIT_FLOW_CONTROL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SCFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/scfc_pkg.sv
package scfc_pkg;

  localparam int AMOUNT_W    = 32;
  localparam int PENDING_W   = 16;
  localparam int FRAME_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [AMOUNT_W-1:0]  MAX_WRITE_BYTES  = 32'd65535;
  localparam logic [FRAME_W-1:0]   FRAME_FLOOR      = 16'd2048;
  localparam logic [FRAME_W-1:0]   MAX_FRAME_RST    = 16'd16384;
  localparam logic [AMOUNT_W-1:0]  OUR_WINDOW_RST   = 32'd262144;
  localparam logic [AMOUNT_W-1:0]  PEER_WINDOW_RST  = 32'd262144;
  localparam logic [AMOUNT_W-1:0]  COUNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [2:0]           REQ_TYPE_LAST    = 3'd6;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_CONSUME    = 3'd1,
    OP_WIN_UPDATE = 3'd2,
    OP_SHUTDOWN   = 3'd3,
    OP_PEER_CLOSE = 3'd4,
    OP_RESET      = 3'd5,
    OP_CLOSE      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_OPEN     = 2'd0,
    MODE_HC_LOCAL = 2'd1,
    MODE_HC_REMOTE = 2'd2,
    MODE_CLOSED   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_STATUS     = 2'd0,
    KIND_DATA       = 2'd1,
    KIND_WIN_UPDATE = 2'd2,
    KIND_CLOSE      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_CLOSED    = 3'd1,
    STAT_WAIT      = 3'd2,
    STAT_BUSY      = 3'd3,
    STAT_ABORTED   = 3'd4,
    STAT_TOO_LONG  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FRAME   = 2'd0,
    CFG_OUR_WINDOW  = 2'd1,
    CFG_PEER_WINDOW = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // decoded request handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  // one result word
  typedef struct packed {
    kind_t               kind;
    logic [AMOUNT_W-1:0] length;
    status_t             status;
    logic                last;
    mode_t               mode;
  } result_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // saturating 32-bit add
  function automatic logic [AMOUNT_W-1:0] sat_add(input logic [AMOUNT_W-1:0] a,
                                                  input logic [AMOUNT_W-1:0] b);
    logic [AMOUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AMOUNT_W] ? COUNT_MAX : s[AMOUNT_W-1:0];
  endfunction

endpackage

FILE: hdl/scfc_req_if.sv
interface scfc_req_if;
  import scfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output req_type, output amount, input ready);
  modport sink   (input valid, input req_type, input amount, output ready);
endinterface

FILE: hdl/scfc_rsp_if.sv
interface scfc_rsp_if;
  import scfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          frame_kind;
  logic [AMOUNT_W-1:0] frame_length;
  logic [2:0]          status;
  logic                last;
  logic [1:0]          session_state;

  modport source (output valid, output frame_kind, output frame_length, output status,
                  output last, output session_state, input ready);
  modport sink   (input valid, input frame_kind, input frame_length, input status,
                  input last, input session_state, output ready);
endinterface

FILE: hdl/scfc_cfg_if.sv
interface scfc_cfg_if;
  import scfc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [AMOUNT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/scfc_front.sv
module scfc_front (
  scfc_req_if.sink        req,
  input  scfc_pkg::q_stat_t q_stat,
  output logic            push,
  output scfc_pkg::cmd_t  push_cmd
);
  import scfc_pkg::*;

  logic known;

  // take a word whenever the queue has room; unknown types are dropped here
  assign known     = (req.req_type <= REQ_TYPE_LAST);
  assign req.ready = !q_stat.full;
  assign push      = req.valid && !q_stat.full && known;

  // classify the request
  always_comb begin
    push_cmd.op     = op_t'(req.req_type);
    push_cmd.amount = req.amount;
  end
endmodule

FILE: hdl/scfc_queue.sv
module scfc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scfc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output scfc_pkg::q_stat_t q_stat,
  output scfc_pkg::cmd_t    pop_cmd
);
  import scfc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.valid = (count != '0);
  assign q_stat.full  = (count == DEPTH_C);
  assign pop_cmd      = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: hdl/scfc_back.sv
module scfc_back (
  input  logic              clk,
  input  logic              rst,
  scfc_cfg_if.sink          cfg,
  scfc_rsp_if.source        rsp,
  input  scfc_pkg::q_stat_t q_stat,
  input  scfc_pkg::cmd_t    q_cmd,
  output logic              pop
);
  import scfc_pkg::*;

  // config registers
  logic [FRAME_W-1:0]  max_frame;
  logic [AMOUNT_W-1:0] our_window;

  // stream state
  state_t               state, state_next;
  mode_t                mode, mode_next;
  logic [AMOUNT_W-1:0]  credit, credit_next;
  logic [PENDING_W-1:0] pending, pending_next;
  logic [AMOUNT_W-1:0]  unacked, unacked_next;
  logic                 had, had_next;

  // output register
  logic    o_valid;
  result_t o_res, o_res_next;
  logic    load;

  logic                 out_free;
  logic [FRAME_W-1:0]   lim;
  logic [PENDING_W-1:0] c_frame;
  logic [PENDING_W-1:0] chunk;
  logic [AMOUNT_W-1:0]  sum;
  logic                 aborted;
  status_t              abort_st;

  assign cfg.ready = 1'b1;
  assign out_free  = !o_valid || rsp.ready;

  // chunk size: min(pending, frame limit, credit)
  assign lim     = (max_frame < FRAME_FLOOR) ? FRAME_FLOOR : max_frame;
  assign c_frame = (pending < lim) ? pending : lim;
  assign chunk   = (credit < {{(AMOUNT_W-PENDING_W){1'b0}}, c_frame})
                   ? credit[PENDING_W-1:0] : c_frame;

  assign sum      = sat_add(unacked, q_cmd.amount);
  assign aborted  = (pending != '0);
  assign abort_st = aborted ? STAT_ABORTED : STAT_OK;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, stream update and result selection
  always_comb begin
    state_next   = state;
    mode_next    = mode;
    credit_next  = credit;
    pending_next = pending;
    unacked_next = unacked;
    had_next     = had;
    pop          = 1'b0;
    load         = 1'b0;
    o_res_next   = '{kind: KIND_STATUS, length: '0, status: STAT_OK, last: 1'b1, mode: mode};
    unique case (state)
      ST_IDLE: begin
        if (q_stat.valid && out_free) begin
          pop = 1'b1;
          unique case (q_cmd.op)
            OP_WRITE: begin
              if (mode == MODE_CLOSED || mode == MODE_HC_LOCAL) begin
                load              = 1'b1;
                o_res_next.status = STAT_CLOSED;
              end else if (pending != '0) begin
                load              = 1'b1;
                o_res_next.status = STAT_BUSY;
              end else if (q_cmd.amount > MAX_WRITE_BYTES) begin
                load              = 1'b1;
                o_res_next.status = STAT_TOO_LONG;
              end else begin
                pending_next = q_cmd.amount[PENDING_W-1:0];
                had_next     = 1'b1;
                state_next   = ST_DRAIN;
              end
            end
            OP_CONSUME: begin
              load = 1'b1;
              if (sum >= (our_window >> 1)) begin
                o_res_next.kind   = KIND_WIN_UPDATE;
                o_res_next.length = sum;
                unacked_next      = '0;
              end else begin
                unacked_next = sum;
              end
            end
            OP_WIN_UPDATE: begin
              credit_next = sat_add(credit, q_cmd.amount);
              had_next    = aborted;
              state_next  = ST_DRAIN;
            end
            OP_SHUTDOWN: begin
              load = 1'b1;
              if (mode == MODE_OPEN) begin
                mode_next       = MODE_HC_LOCAL;
                o_res_next.kind = KIND_CLOSE;
                o_res_next.mode = MODE_HC_LOCAL;
              end else if (mode == MODE_HC_REMOTE) begin
                mode_next       = MODE_CLOSED;
                o_res_next.kind = KIND_CLOSE;
                o_res_next.mode = MODE_CLOSED;
              end else begin
                o_res_next.status = STAT_CLOSED;
              end
            end
            OP_PEER_CLOSE: begin
              load = 1'b1;
              if (mode == MODE_HC_LOCAL) begin
                mode_next       = MODE_CLOSED;
                o_res_next.mode = MODE_CLOSED;
              end else if (mode == MODE_OPEN) begin
                mode_next       = MODE_HC_REMOTE;
                o_res_next.mode = MODE_HC_REMOTE;
              end
            end
            OP_RESET: begin
              load              = 1'b1;
              pending_next      = '0;
              mode_next         = MODE_CLOSED;
              o_res_next.status = abort_st;
              o_res_next.mode   = MODE_CLOSED;
            end
            OP_CLOSE: begin
              load              = 1'b1;
              pending_next      = '0;
              mode_next         = MODE_CLOSED;
              o_res_next.status = abort_st;
              o_res_next.mode   = MODE_CLOSED;
              if (mode != MODE_CLOSED) begin
                o_res_next.kind = KIND_CLOSE;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load = 1'b1;
          if (pending != '0 && credit != '0) begin
            // one data chunk per cycle while the output register is free
            o_res_next.kind   = KIND_DATA;
            o_res_next.length = {{(AMOUNT_W-PENDING_W){1'b0}}, chunk};
            o_res_next.last   = 1'b0;
            credit_next       = credit - {{(AMOUNT_W-PENDING_W){1'b0}}, chunk};
            pending_next      = pending - chunk;
          end else begin
            // closing status word
            o_res_next.status = (had && pending != '0) ? STAT_WAIT : STAT_OK;
            state_next        = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // stream state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame  <= MAX_FRAME_RST;
      our_window <= OUR_WINDOW_RST;
      mode       <= MODE_OPEN;
      credit     <= PEER_WINDOW_RST;
      pending    <= '0;
      unacked    <= '0;
      had        <= 1'b0;
    end else begin
      mode    <= mode_next;
      pending <= pending_next;
      unacked <= unacked_next;
      had     <= had_next;
      // a peer window write restarts the send credit
      if (cfg.valid && cfg.index == CFG_PEER_WINDOW) begin
        credit <= cfg.data;
      end else begin
        credit <= credit_next;
      end
      if (cfg.valid) begin
        case (cfg.index)
          CFG_MAX_FRAME:   max_frame  <= cfg.data[FRAME_W-1:0];
          CFG_OUR_WINDOW:  our_window <= cfg.data;
          default:         max_frame  <= max_frame;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_res <= o_res_next;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.frame_kind    = o_res.kind;
  assign rsp.frame_length  = o_res.length;
  assign rsp.status        = o_res.status;
  assign rsp.last          = o_res.last;
  assign rsp.session_state = o_res.mode;
endmodule

FILE: hdl/stream_credit_flow_control.sv
// Channel  Dir  Fields                                                 Done when
// req      in   req_type, amount                                       valid && ready
// rsp      out  frame_kind, frame_length, status, last, session_state  valid && ready
// cfg      in   index, data                                            valid && ready
//
// A control request gives one word from the back end.
// A write or window update that is taken is set up, then gives up to 32 data chunks
// and a closing status word; a refused write gives one status word.
// Requests are decoded into a 2-word queue, so req can take two words while rsp stalls;
// the back end stops only when its output register is full and not taken.
// rst is synchronous and restores the register defaults and an open stream.
module stream_credit_flow_control (
  input  logic       clk,
  input  logic       rst,
  scfc_req_if.sink   req,
  scfc_rsp_if.source rsp,
  scfc_cfg_if.sink   cfg
);
  import scfc_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;

  scfc_front u_front (
    .req      (req),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  scfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_stat   (q_stat),
    .pop_cmd  (pop_cmd)
  );

  scfc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .rsp    (rsp),
    .q_stat (q_stat),
    .q_cmd  (pop_cmd),
    .pop    (pop)
  );
endmodule

FILE: hdl/scfc_checker.sv
`include "stream_credit_flow_control_assert.svh"

module scfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  frame_kind,
  input logic [31:0] frame_length,
  input logic [2:0]  status,
  input logic        last,
  input logic [1:0]  session_state
);
  import scfc_pkg::*;

  // a stalled word keeps its kind, length and last flag
  `SCFC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(frame_kind) && $stable(frame_length) && $stable(last), "rsp word changed while stalled")

  // data chunks are never last, carry ok status, are nonzero and fit in 16 bits
  `SCFC_ASSERT_IMP(a_chunk_shape, rsp_valid && frame_kind == KIND_DATA, !last && status == STAT_OK && frame_length != 0 && frame_length[31:16] == 16'd0, "bad data chunk")

  // close frames carry no length and leave the stream half closed or closed
  `SCFC_ASSERT_IMP(a_close_shape, rsp_valid && frame_kind == KIND_CLOSE, frame_length == 0 && last && session_state != MODE_OPEN, "bad close frame")

  // status-only words carry no length and end the request
  `SCFC_ASSERT_IMP(a_status_shape, rsp_valid && frame_kind == KIND_STATUS, frame_length == 0 && last, "bad status word")
endmodule

bind stream_credit_flow_control scfc_checker u_scfc_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .frame_kind    (rsp.frame_kind),
  .frame_length  (rsp.frame_length),
  .status        (rsp.status),
  .last          (rsp.last),
  .session_state (rsp.session_state)
);

FILE: verif/stream_credit_flow_control_tb.sv
`timescale 1ns / 1ps

module stream_credit_flow_control_tb;
  import scfc_pkg::*;

  localparam logic [2:0] OP_UNUSED      = 3'd7;
  localparam logic [1:0] CFG_SPARE      = 2'd3;
  localparam int         QUIET_CYCLES   = 120;
  localparam int         WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;

  scfc_req_if req_bus ();
  scfc_rsp_if rsp_bus ();
  scfc_cfg_if cfg_bus ();

  stream_credit_flow_control u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  // one step of the scripted sequence: a request or a register write
  typedef struct {
    bit          is_cfg;
    logic [2:0]  code;
    logic [31:0] value;
    bit          typed;
    kind_t       kind;
    logic [31:0] length;
    status_t     status;
  } plan_row_t;

  plan_row_t plan[$];
  result_t   frames_due[$];

  // shadow of the stream state and registers
  mode_t       link_mode;
  logic [31:0] credit;
  logic [15:0] backlog;
  logic [31:0] unacked;
  logic [15:0] frame_cap;
  logic [31:0] rx_window;
  logic [31:0] tx_window;

  int    gap_pct;
  int    stall_pct;
  int    faults;
  int    items_sent;
  int    regs_written;
  int    words_checked;
  int    chunks_seen;
  string ending_path;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
    return (b > COUNT_MAX - a) ? COUNT_MAX : a + b;
  endfunction

  function automatic result_t make_word(kind_t k, logic [31:0] len, status_t st);
    result_t w;
    w.kind   = k;
    w.length = len;
    w.status = st;
    w.last   = 1'b0;
    w.mode   = link_mode;
    return w;
  endfunction

  // work out the words one accepted request produces and queue them
  function automatic void forecast_words(logic [2:0] code, logic [31:0] amt);
    result_t     words[$];
    logic [31:0] cap;
    logic [31:0] chunk;
    bit          had_backlog;
    bit          flush;
    status_t     st;
    cap         = (frame_cap < FRAME_FLOOR) ? 32'(FRAME_FLOOR) : 32'(frame_cap);
    had_backlog = (backlog != 0);
    flush       = 1'b0;
    st          = had_backlog ? STAT_ABORTED : STAT_OK;
    case (code)
      OP_WRITE: begin
        if (link_mode == MODE_CLOSED || link_mode == MODE_HC_LOCAL)
          words.push_back(make_word(KIND_STATUS, '0, STAT_CLOSED));
        else if (had_backlog)
          words.push_back(make_word(KIND_STATUS, '0, STAT_BUSY));
        else if (amt > MAX_WRITE_BYTES)
          words.push_back(make_word(KIND_STATUS, '0, STAT_TOO_LONG));
        else begin
          backlog = amt[15:0];
          flush   = 1'b1;
        end
      end
      OP_CONSUME: begin
        unacked = clamp_sum(unacked, amt);
        if (unacked >= (rx_window >> 1)) begin
          words.push_back(make_word(KIND_WIN_UPDATE, unacked, STAT_OK));
          unacked = '0;
        end else begin
          words.push_back(make_word(KIND_STATUS, '0, STAT_OK));
        end
      end
      OP_WIN_UPDATE: begin
        credit = clamp_sum(credit, amt);
        flush  = 1'b1;
      end
      OP_SHUTDOWN: begin
        if (link_mode == MODE_OPEN) begin
          link_mode = MODE_HC_LOCAL;
          words.push_back(make_word(KIND_CLOSE, '0, STAT_OK));
        end else if (link_mode == MODE_HC_REMOTE) begin
          link_mode = MODE_CLOSED;
          words.push_back(make_word(KIND_CLOSE, '0, STAT_OK));
        end else begin
          words.push_back(make_word(KIND_STATUS, '0, STAT_CLOSED));
        end
      end
      OP_PEER_CLOSE: begin
        if (link_mode == MODE_HC_LOCAL) link_mode = MODE_CLOSED;
        else if (link_mode == MODE_OPEN) link_mode = MODE_HC_REMOTE;
        words.push_back(make_word(KIND_STATUS, '0, STAT_OK));
      end
      OP_RESET: begin
        backlog   = '0;
        link_mode = MODE_CLOSED;
        words.push_back(make_word(KIND_STATUS, '0, st));
      end
      OP_CLOSE: begin
        backlog = '0;
        if (link_mode != MODE_CLOSED) begin
          link_mode = MODE_CLOSED;
          words.push_back(make_word(KIND_CLOSE, '0, st));
        end else begin
          words.push_back(make_word(KIND_STATUS, '0, st));
        end
      end
      default: ;
    endcase

    // send what credit allows, then the status word
    if (flush) begin
      while (backlog != 0 && credit != 0) begin
        chunk = {16'd0, backlog};
        if (chunk > cap) chunk = cap;
        if (chunk > credit) chunk = credit;
        credit  = credit - chunk;
        backlog = backlog - chunk[15:0];
        words.push_back(make_word(KIND_DATA, chunk, STAT_OK));
      end
      if (backlog != 0 && (code == OP_WRITE || had_backlog)) st = STAT_WAIT;
      else st = STAT_OK;
      words.push_back(make_word(KIND_STATUS, '0, st));
    end

    if (words.size() != 0) words[words.size()-1].last = 1'b1;
    foreach (words[i]) frames_due.push_back(words[i]);
  endfunction

  function automatic void plan_req(logic [2:0] code, logic [31:0] v);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.code   = code;
    r.value  = v;
    r.typed  = 1'b0;
    r.kind   = KIND_STATUS;
    r.length = '0;
    r.status = STAT_OK;
    plan.push_back(r);
  endfunction

  function automatic void plan_chk(logic [2:0] code, logic [31:0] v, kind_t k,
                                   logic [31:0] len, status_t st);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.code   = code;
    r.value  = v;
    r.typed  = 1'b1;
    r.kind   = k;
    r.length = len;
    r.status = st;
    plan.push_back(r);
  endfunction

  function automatic void plan_cfg(logic [1:0] idx, logic [31:0] v);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.code   = {1'b0, idx};
    r.value  = v;
    r.typed  = 1'b0;
    r.kind   = KIND_STATUS;
    r.length = '0;
    r.status = STAT_OK;
    plan.push_back(r);
  endfunction

  function automatic logic [31:0] pick_window();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(0, 3);
      2:       return $urandom_range(1, 20000);
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom;
      default: return $urandom_range(4096, 300000);
    endcase
  endfunction

  // one request word, held until taken
  task automatic send_request(logic [2:0] code, logic [31:0] amt);
    int gap;
    gap = ($urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= code;
    req_bus.amount   <= amt;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    items_sent++;
    forecast_words(code, amt);
  endtask

  // register write; valid stays up when another write follows
  task automatic write_reg(logic [1:0] idx, logic [31:0] val, bit more);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (!more) cfg_bus.valid <= 1'b0;
    regs_written++;
    case (idx)
      CFG_MAX_FRAME:   frame_cap = val[15:0];
      CFG_OUR_WINDOW:  rx_window = val;
      CFG_PEER_WINDOW: begin
        tx_window = val;
        credit    = val;
      end
      default: ;
    endcase
  endtask

  // hold off until every word is back and the back end has gone quiet
  task automatic wait_quiet();
    req_bus.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic run_plan();
    plan_row_t row;
    int        n;
    for (int i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_quiet();
        write_reg(row.code[1:0], row.value, (i + 1 < plan.size()) && plan[i+1].is_cfg);
      end else begin
        send_request(row.code, row.value);
        if (row.typed) begin
          n = frames_due.size() - 1;
          frames_due[n].kind   = row.kind;
          frames_due[n].length = row.length;
          frames_due[n].status = row.status;
        end
      end
    end
    plan.delete();
  endtask

  // random registers, then mostly writes, consumes and credit updates
  task automatic random_phase(int count);
    logic [2:0]  code;
    logic [31:0] amt;
    int          roll;
    logic [31:0] cap_val;
    wait_quiet();
    case ($urandom_range(0, 4))
      0:       cap_val = $urandom_range(0, 2047);
      1:       cap_val = 32'd2048;
      2:       cap_val = 32'd65535;
      default: cap_val = $urandom_range(2048, 65535);
    endcase
    write_reg(CFG_MAX_FRAME, cap_val, 1'b1);
    write_reg(CFG_OUR_WINDOW, pick_window(), 1'b1);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom, 1'b1);
    write_reg(CFG_PEER_WINDOW, pick_window(), 1'b0);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        code = OP_WRITE;
        case ($urandom_range(0, 9))
          0:       amt = '0;
          1:       amt = 32'd65535;
          2:       amt = $urandom;
          3, 4, 5: amt = $urandom_range(1, 4000);
          default: amt = $urandom_range(0, 65535);
        endcase
      end else if (roll < 60) begin
        code = OP_CONSUME;
        case ($urandom_range(0, 9))
          0:       amt = 32'hFFFF_FFFF;
          1:       amt = $urandom;
          default: amt = $urandom_range(0, 70000);
        endcase
      end else if (roll < 92) begin
        code = OP_WIN_UPDATE;
        case ($urandom_range(0, 9))
          0:       amt = '0;
          1:       amt = 32'hFFFF_FFFF;
          2:       amt = $urandom;
          default: amt = $urandom_range(1, 6000);
        endcase
      end else if (roll < 95) begin
        code = OP_PEER_CLOSE;
        amt  = $urandom;
      end else begin
        code = OP_UNUSED;
        amt  = $urandom;
      end
      send_request(code, amt);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t due;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected word: kind %0d length %0d status %0d", rsp_bus.frame_kind,
               rsp_bus.frame_length, rsp_bus.status);
        faults++;
      end else begin
        due = frames_due.pop_front();
        words_checked++;
        if (rsp_bus.frame_kind == KIND_DATA) chunks_seen++;
        if (rsp_bus.frame_kind !== due.kind) begin
          $error("frame_kind: expected %0d, got %0d", due.kind, rsp_bus.frame_kind);
          faults++;
        end
        if (rsp_bus.frame_length !== due.length) begin
          $error("frame_length: expected %0d, got %0d", due.length, rsp_bus.frame_length);
          faults++;
        end
        if (rsp_bus.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
          faults++;
        end
        if (rsp_bus.last !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, rsp_bus.last);
          faults++;
        end
        if (rsp_bus.session_state !== due.mode) begin
          $error("session_state: expected %0d, got %0d", due.mode, rsp_bus.session_state);
          faults++;
        end
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int hold;
    hold = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        hold = $urandom_range(1, 12) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no handshake on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int path;
    faults        = 0;
    items_sent    = 0;
    regs_written  = 0;
    words_checked = 0;
    chunks_seen   = 0;
    gap_pct       = 25;
    stall_pct     = 25;

    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= '0;
    req_bus.amount   <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= '0;
    cfg_bus.data     <= '0;

    link_mode = MODE_OPEN;
    frame_cap = MAX_FRAME_RST;
    rx_window = OUR_WINDOW_RST;
    tx_window = PEER_WINDOW_RST;
    credit    = PEER_WINDOW_RST;
    backlog   = '0;
    unacked   = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // register defaults: length limits, ack threshold, saturation
    plan_chk(OP_WRITE, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
    plan_chk(OP_WRITE, 32'd65536, KIND_STATUS, 32'd0, STAT_TOO_LONG);
    plan_chk(OP_WRITE, 32'hFFFF_FFFF, KIND_STATUS, 32'd0, STAT_TOO_LONG);
    plan_req(OP_WRITE, 32'd65535);
    plan_chk(OP_CONSUME, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
    plan_req(OP_CONSUME, 32'd131071);
    plan_chk(OP_CONSUME, 32'd1, KIND_WIN_UPDATE, 32'd131072, STAT_OK);
    plan_chk(OP_CONSUME, 32'hFFFF_FFFF, KIND_WIN_UPDATE, 32'hFFFF_FFFF, STAT_OK);
    plan_chk(OP_WIN_UPDATE, 32'hFFFF_FFFF, KIND_STATUS, 32'd0, STAT_OK);
    plan_req(OP_UNUSED, 32'h5A5A_A5A5);
    // frame limit below the floor, zero windows: credit starvation
    plan_cfg(CFG_MAX_FRAME, 32'd0);
    plan_cfg(CFG_OUR_WINDOW, 32'd0);
    plan_cfg(CFG_PEER_WINDOW, 32'd0);
    plan_chk(OP_WRITE, 32'd5000, KIND_STATUS, 32'd0, STAT_WAIT);
    plan_chk(OP_WRITE, 32'd10, KIND_STATUS, 32'd0, STAT_BUSY);
    plan_chk(OP_WRITE, 32'd70000, KIND_STATUS, 32'd0, STAT_BUSY);
    plan_chk(OP_CONSUME, 32'd0, KIND_WIN_UPDATE, 32'd0, STAT_OK);
    plan_chk(OP_WIN_UPDATE, 32'd1, KIND_STATUS, 32'd0, STAT_WAIT);
    plan_chk(OP_WIN_UPDATE, 32'd0, KIND_STATUS, 32'd0, STAT_WAIT);
    plan_chk(OP_WIN_UPDATE, 32'd100000, KIND_STATUS, 32'd0, STAT_OK);
    plan_req(OP_WRITE, 32'd65535);
    // top-end windows, frame limit one under the floor
    plan_cfg(CFG_MAX_FRAME, 32'd2047);
    plan_cfg(CFG_OUR_WINDOW, 32'hFFFF_FFFF);
    plan_cfg(CFG_SPARE, $urandom);
    plan_cfg(CFG_PEER_WINDOW, 32'hFFFF_FFFF);
    plan_req(OP_CONSUME, 32'h7FFF_FFFE);
    plan_chk(OP_CONSUME, 32'hFFFF_FFFF, KIND_WIN_UPDATE, 32'hFFFF_FFFF, STAT_OK);
    plan_req(OP_WRITE, 32'd65535);
    plan_chk(OP_WIN_UPDATE, 32'hFFFF_FFFF, KIND_STATUS, 32'd0, STAT_OK);
    // largest frame, threshold of one byte
    plan_cfg(CFG_MAX_FRAME, 32'd65535);
    plan_cfg(CFG_OUR_WINDOW, 32'd2);
    plan_chk(OP_CONSUME, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
    plan_chk(OP_CONSUME, 32'd1, KIND_WIN_UPDATE, 32'd1, STAT_OK);
    plan_req(OP_WRITE, 32'd65535);
    run_plan();

    // random traffic; one phase runs with no idling at all
    for (int p = 0; p < 4; p++) begin
      gap_pct   = (p == 1) ? 0 : 20;
      stall_pct = (p == 1) ? 0 : 20;
      random_phase(16);
    end

    // lifecycle ending with a write parked on zero credit
    gap_pct   = 20;
    stall_pct = 20;
    path      = $urandom_range(0, 2);
    plan_req(OP_WIN_UPDATE, 32'hFFFF_FFFF);
    plan_cfg(CFG_MAX_FRAME, 32'd2048);
    plan_cfg(CFG_PEER_WINDOW, 32'd0);
    plan_chk(OP_WRITE, 32'd5000, KIND_STATUS, 32'd0, STAT_WAIT);
    plan_chk(OP_WRITE, 32'd7, KIND_STATUS, 32'd0, STAT_BUSY);
    plan_chk(OP_WIN_UPDATE, 32'd1000, KIND_STATUS, 32'd0, STAT_WAIT);
    case (path)
      0: begin
        ending_path = "local shutdown first, reset aborts";
        plan_chk(OP_SHUTDOWN, 32'd0, KIND_CLOSE, 32'd0, STAT_OK);
        plan_chk(OP_SHUTDOWN, 32'd0, KIND_STATUS, 32'd0, STAT_CLOSED);
        plan_chk(OP_WRITE, 32'd10, KIND_STATUS, 32'd0, STAT_CLOSED);
        plan_chk(OP_PEER_CLOSE, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
        plan_chk(OP_RESET, 32'd0, KIND_STATUS, 32'd0, STAT_ABORTED);
      end
      1: begin
        ending_path = "peer close first, close aborts when closed";
        plan_chk(OP_PEER_CLOSE, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
        plan_chk(OP_PEER_CLOSE, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
        plan_chk(OP_WRITE, 32'd10, KIND_STATUS, 32'd0, STAT_BUSY);
        plan_chk(OP_SHUTDOWN, 32'd0, KIND_CLOSE, 32'd0, STAT_OK);
        plan_chk(OP_CLOSE, 32'd0, KIND_STATUS, 32'd0, STAT_ABORTED);
      end
      default: begin
        ending_path = "close frame aborts the parked write";
        plan_chk(OP_CLOSE, 32'd0, KIND_CLOSE, 32'd0, STAT_ABORTED);
      end
    endcase
    plan_chk(OP_CLOSE, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
    plan_chk(OP_RESET, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
    plan_chk(OP_WRITE, 32'd0, KIND_STATUS, 32'd0, STAT_CLOSED);
    plan_chk(OP_SHUTDOWN, 32'd0, KIND_STATUS, 32'd0, STAT_CLOSED);
    plan_chk(OP_PEER_CLOSE, 32'd0, KIND_STATUS, 32'd0, STAT_OK);
    plan_chk(OP_WIN_UPDATE, 32'hFFFF_FFFF, KIND_STATUS, 32'd0, STAT_OK);
    plan_req(OP_CONSUME, 32'd3);
    plan_req(OP_UNUSED, $urandom);
    run_plan();

    // closing stretch: any request type, no idling
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 0; i < 15; i++)
      send_request(3'($urandom_range(0, 7)), ($urandom_range(0, 1) != 0) ? $urandom :
                   32'($urandom_range(0, 70000)));

    wait_quiet();
    $display("Sent %0d requests and %0d register writes; checked %0d words (%0d data chunks).",
             items_sent, regs_written, words_checked, chunks_seen);
    $display("Stream ending: %s.", ending_path);
    if (faults == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/scfc_pkg.sv
hdl/scfc_req_if.sv
hdl/scfc_rsp_if.sv
hdl/scfc_cfg_if.sv
hdl/scfc_front.sv
hdl/scfc_queue.sv
hdl/scfc_back.sv
hdl/stream_credit_flow_control.sv
hdl/scfc_checker.sv
verif/stream_credit_flow_control_tb.sv
